// ----- rtl/affine_gap_global_aligner_core_defines.svh -----
// Assertion macros for the affine-gap aligner core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef AFFINE_GAP_GLOBAL_ALIGNER_CORE_DEFINES_SVH
`define AFFINE_GAP_GLOBAL_ALIGNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define AGGA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AGGA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/agga_pkg.sv -----
// Shared types, constants and score helpers for the affine-gap aligner.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package agga_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int ALPHA       = 26;
    localparam int SYM_W       = 5;
    localparam int POS_W       = 5;
    localparam int SCORE_W     = 16;
    localparam int OP_W        = 2;
    localparam int GO_W        = 7;
    localparam int GE_W        = 5;
    localparam int ENTRY_W     = 5;
    localparam int CFG_AW      = 1;

    typedef logic signed [SCORE_W-1:0] score_t;
    localparam score_t NEG_INF = 16'sh8000;

    // Input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_FIRST  = 2'd0,
        OP_SECOND = 2'd1,
        OP_TABLE  = 2'd2,
        OP_ALIGN  = 2'd3
    } op_e;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_GAP_OPEN   = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_GAP_EXTEND = 1'b1;

    // Traceback modes
    typedef enum logic [1:0] {
        MODE_M,
        MODE_H,
        MODE_V
    } mode_t;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT_ORG,
        CMD_INIT_COL,
        CMD_COL_START,
        CMD_COL_LAT,
        CMD_COL_END,
        CMD_CELL_RD,
        CMD_CELL_SUB,
        CMD_CELL_CALC,
        CMD_TB_INIT,
        CMD_TB_RD,
        CMD_TB_SET,
        CMD_TB_A,
        CMD_TB_B,
        CMD_TB_C,
        CMD_TAIL_WR,
        CMD_EMIT_LD,
        CMD_FINISH
    } dp_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic init_more;
        logic col_last;
        logic n2_zero;
        logic cell_last;
        logic tb_loop;
        logic tail_any;
        logic cnt_zero;
        logic out_last;
        logic out_taken;
    } dp_status_t;

    // One traceback entry
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             pair;
        logic [POS_W-1:0] pos1;
        logic [POS_W-1:0] pos2;
    } trace_t;

    // Add a cost, keeping minus infinity sticky
    function automatic score_t add_cost(score_t a, score_t c);
        add_cost = (a == NEG_INF) ? NEG_INF : score_t'(a + c);
    endfunction

    function automatic score_t max2(score_t a, score_t b);
        max2 = (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/agga_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module agga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/agga_ctrl.sv -----
// Sequencing state machine for the aligner: load, fill, traceback, emit.
// Depends on agga_pkg; drives agga_dp through a command code.
`timescale 1ns / 1ps
module agga_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [agga_pkg::OP_W-1:0] s_op,
    output logic                  s_ready,
    input  agga_pkg::dp_status_t  status,
    output agga_pkg::dp_cmd_t     cmd
);
    import agga_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_ORG,
        ST_INIT_COL,
        ST_COL_START,
        ST_COL_LAT,
        ST_COL_END,
        ST_CELL_RD,
        ST_CELL_SUB,
        ST_CELL_CALC,
        ST_TB_INIT,
        ST_TB_RD,
        ST_TB_SET,
        ST_TB_CHK,
        ST_TB_A,
        ST_TB_B,
        ST_TB_C,
        ST_TAIL_WR,
        ST_TAIL_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (op_e'(s_op) == OP_ALIGN)) begin
                    state_next = ST_INIT_ORG;
                end
            end
            ST_INIT_ORG:  state_next = ST_INIT_COL;
            ST_INIT_COL: begin
                if (!status.init_more) begin
                    state_next = status.n2_zero ? ST_TB_INIT : ST_COL_START;
                end
            end
            ST_COL_START: state_next = ST_COL_LAT;
            ST_COL_LAT:   state_next = status.init_more ? ST_CELL_RD : ST_COL_END;
            ST_CELL_RD:   state_next = ST_CELL_SUB;
            ST_CELL_SUB:  state_next = ST_CELL_CALC;
            ST_CELL_CALC: state_next = status.cell_last ? ST_COL_END : ST_CELL_RD;
            ST_COL_END:   state_next = status.col_last ? ST_TB_INIT : ST_COL_START;
            ST_TB_INIT:   state_next = ST_TB_RD;
            ST_TB_RD:     state_next = ST_TB_SET;
            ST_TB_SET:    state_next = ST_TB_CHK;
            ST_TB_CHK: begin
                if (status.tb_loop) begin
                    state_next = ST_TB_A;
                end else if (status.tail_any) begin
                    state_next = ST_TAIL_WR;
                end else begin
                    state_next = status.cnt_zero ? ST_FINISH : ST_EMIT_RD;
                end
            end
            ST_TB_A:      state_next = ST_TB_B;
            ST_TB_B:      state_next = ST_TB_C;
            ST_TB_C:      state_next = ST_TB_CHK;
            ST_TAIL_WR:   state_next = ST_TAIL_CHK;
            ST_TAIL_CHK: begin
                if (status.tail_any) begin
                    state_next = ST_TAIL_WR;
                end else begin
                    state_next = status.cnt_zero ? ST_FINISH : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (status.out_taken) begin
                    state_next = status.out_last ? ST_FINISH : ST_EMIT_RD;
                end
            end
            ST_FINISH:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Hold state and the input ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

    // Decode state into a datapath command
    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                cmd = (s_valid && (op_e'(s_op) != OP_ALIGN)) ? CMD_LOAD : CMD_NONE;
            end
            ST_INIT_ORG:  cmd = CMD_INIT_ORG;
            ST_INIT_COL:  cmd = CMD_INIT_COL;
            ST_COL_START: cmd = CMD_COL_START;
            ST_COL_LAT:   cmd = CMD_COL_LAT;
            ST_COL_END:   cmd = CMD_COL_END;
            ST_CELL_RD:   cmd = CMD_CELL_RD;
            ST_CELL_SUB:  cmd = CMD_CELL_SUB;
            ST_CELL_CALC: cmd = CMD_CELL_CALC;
            ST_TB_INIT:   cmd = CMD_TB_INIT;
            ST_TB_RD:     cmd = CMD_TB_RD;
            ST_TB_SET:    cmd = CMD_TB_SET;
            ST_TB_A:      cmd = CMD_TB_A;
            ST_TB_B:      cmd = CMD_TB_B;
            ST_TB_C:      cmd = CMD_TB_C;
            ST_TAIL_WR:   cmd = CMD_TAIL_WR;
            ST_EMIT_LD:   cmd = CMD_EMIT_LD;
            ST_FINISH:    cmd = CMD_FINISH;
            default:      cmd = CMD_NONE;
        endcase
    end

endmodule

// ----- rtl/agga_dp.sv -----
// Datapath: letter, table and score memories, fill arithmetic, traceback
// and output register. Depends on agga_pkg and agga_ram.
`timescale 1ns / 1ps
module agga_dp #(
    parameter int MAX_LEN = agga_pkg::MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  agga_pkg::dp_cmd_t              cmd,
    output agga_pkg::dp_status_t           status,
    input  logic [agga_pkg::OP_W-1:0]      s_op,
    input  logic [agga_pkg::SYM_W-1:0]     s_symbol,
    input  logic [agga_pkg::SYM_W-1:0]     s_column_symbol,
    input  logic signed [agga_pkg::ENTRY_W-1:0] s_entry_score,
    input  logic                           cfg_valid,
    input  logic [agga_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [agga_pkg::GO_W-1:0]      cfg_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [agga_pkg::SYM_W-1:0]     m_merged_symbol,
    output logic                           m_is_pair,
    output logic [agga_pkg::POS_W-1:0]     m_first_position,
    output logic [agga_pkg::POS_W-1:0]     m_second_position,
    output logic                           m_last
);
    import agga_pkg::*;

    localparam int DIM   = MAX_LEN + 1;
    localparam int IW    = $clog2(MAX_LEN + 2);
    localparam int LAW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SAW   = $clog2(DIM * DIM);
    localparam int TAW   = $clog2(ALPHA * ALPHA);
    localparam int RBD   = 2 * MAX_LEN;
    localparam int RAW   = $clog2(RBD);
    localparam int CW    = $clog2(RBD + 1);
    localparam int TR_W  = $bits(trace_t);

    // Control registers
    logic signed [GO_W-1:0] go_reg;
    logic signed [GE_W-1:0] ge_reg;
    logic [IW-1:0]          n1_reg, n2_reg;
    logic                   m_valid_reg;

    // Working registers
    logic [IW-1:0]    i_reg, j_reg;
    score_t           col_bnd_reg, row_bnd_reg, row_prev_reg;
    score_t           diag_reg, up_m_reg, up_v_reg, left_m_reg, left_h_reg;
    score_t           cur_m_reg, cur_h_reg, cur_v_reg;
    logic [SYM_W-1:0] l1_reg, l2_reg;
    mode_t            mode_reg;
    logic [CW-1:0]    cnt_reg, k_reg;
    trace_t           out_reg;
    logic             last_reg;

    // Memory ports
    logic             l1_we, l2_we, tb_we, rb_we;
    logic [SYM_W-1:0] l1_q, l2_q;
    logic [ENTRY_W-1:0] sub_q;
    logic [TAW-1:0]   tb_wa, tb_ra;
    logic             sc_we;
    logic [SAW-1:0]   sc_wa, sc_ra;
    score_t           sc_wm, sc_wh, sc_wv;
    logic [SCORE_W-1:0] m_q, h_q, v_q;
    trace_t           rb_wd;
    logic [TR_W-1:0]  rb_q;
    trace_t           rb_ent;

    score_t           go_s, ge_s, m_q_s, h_q_s, v_q_s;
    score_t           hx, vx, dx, mx;
    logic [SAW-1:0]   row_base, cell_ij;
    logic             op_first, op_second, op_table, sym_ok, col_ok, tb_step;
    trace_t           tb_ent;

    assign go_s  = score_t'(go_reg);
    assign ge_s  = score_t'(ge_reg);
    assign m_q_s = $signed(m_q);
    assign h_q_s = $signed(h_q);
    assign v_q_s = $signed(v_q);
    assign rb_ent = trace_t'(rb_q);

    assign op_first  = (cmd == CMD_LOAD) && (op_e'(s_op) == OP_FIRST);
    assign op_second = (cmd == CMD_LOAD) && (op_e'(s_op) == OP_SECOND);
    assign op_table  = (cmd == CMD_LOAD) && (op_e'(s_op) == OP_TABLE);
    assign sym_ok    = (s_symbol < SYM_W'(ALPHA));
    assign col_ok    = (s_column_symbol < SYM_W'(ALPHA));

    // Letter stores: append on load, read at the current i-1 / j-1
    assign l1_we = op_first && sym_ok && (n1_reg < IW'(MAX_LEN));
    assign l2_we = op_second && sym_ok && (n2_reg < IW'(MAX_LEN));

    agga_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(LAW)) u_first_ram (
        .aclk    (aclk),
        .wr_en   (l1_we),
        .wr_addr (LAW'(n1_reg)),
        .wr_data (s_symbol),
        .rd_addr (LAW'(i_reg - 1'b1)),
        .rd_data (l1_q)
    );

    agga_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .AW(LAW)) u_second_ram (
        .aclk    (aclk),
        .wr_en   (l2_we),
        .wr_addr (LAW'(n2_reg)),
        .wr_data (s_symbol),
        .rd_addr (LAW'(j_reg - 1'b1)),
        .rd_data (l2_q)
    );

    // Substitution table: row * 26 + column
    assign tb_we = op_table && sym_ok && col_ok;
    assign tb_wa = TAW'(s_symbol) * TAW'(ALPHA) + TAW'(s_column_symbol);
    assign tb_ra = TAW'(l1_q) * TAW'(ALPHA) + TAW'(l2_reg);

    agga_ram #(.WIDTH(ENTRY_W), .DEPTH(ALPHA * ALPHA), .AW(TAW)) u_table_ram (
        .aclk    (aclk),
        .wr_en   (tb_we),
        .wr_addr (tb_wa),
        .wr_data (s_entry_score),
        .rd_addr (tb_ra),
        .rd_data (sub_q)
    );

    // Cell recurrence
    assign hx = add_cost(max2(add_cost(left_m_reg, go_s), left_h_reg), ge_s);
    assign vx = add_cost(max2(add_cost(up_m_reg, go_s), up_v_reg), ge_s);
    assign dx = score_t'(diag_reg + score_t'($signed(sub_q)));
    assign mx = max2(max2(hx, vx), dx);

    assign row_base = SAW'(i_reg) * SAW'(DIM);
    assign cell_ij  = row_base + SAW'(j_reg);

    // Score memory addressing and write data
    always_comb begin
        sc_we = 1'b0;
        sc_wa = cell_ij;
        sc_wm = mx;
        sc_wh = hx;
        sc_wv = vx;
        sc_ra = cell_ij;
        unique case (cmd)
            CMD_INIT_ORG: begin
                sc_we = 1'b1;
                sc_wa = '0;
                sc_wm = '0;
                sc_wh = NEG_INF;
                sc_wv = NEG_INF;
            end
            CMD_INIT_COL: begin
                sc_we = status.init_more;
                sc_wa = row_base;
                sc_wm = col_bnd_reg;
                sc_wh = NEG_INF;
                sc_wv = col_bnd_reg;
            end
            CMD_COL_START: begin
                sc_we = 1'b1;
                sc_wa = SAW'(j_reg);
                sc_wm = row_bnd_reg;
                sc_wh = row_bnd_reg;
                sc_wv = NEG_INF;
            end
            CMD_CELL_RD: sc_ra = cell_ij - SAW'(1);
            CMD_CELL_CALC: sc_we = 1'b1;
            CMD_TB_B: begin
                sc_ra = (mode_reg == MODE_V) ? (cell_ij - SAW'(DIM)) : (cell_ij - SAW'(1));
            end
            default: ;
        endcase
    end

    agga_ram #(.WIDTH(SCORE_W), .DEPTH(DIM * DIM), .AW(SAW)) u_match_ram (
        .aclk (aclk), .wr_en (sc_we), .wr_addr (sc_wa), .wr_data (sc_wm),
        .rd_addr (sc_ra), .rd_data (m_q)
    );

    agga_ram #(.WIDTH(SCORE_W), .DEPTH(DIM * DIM), .AW(SAW)) u_horiz_ram (
        .aclk (aclk), .wr_en (sc_we), .wr_addr (sc_wa), .wr_data (sc_wh),
        .rd_addr (sc_ra), .rd_data (h_q)
    );

    agga_ram #(.WIDTH(SCORE_W), .DEPTH(DIM * DIM), .AW(SAW)) u_vert_ram (
        .aclk (aclk), .wr_en (sc_we), .wr_addr (sc_wa), .wr_data (sc_wv),
        .rd_addr (sc_ra), .rd_data (v_q)
    );

    // Traceback step decision and entry
    assign tb_step = (mode_reg != MODE_M) ||
                     ((cur_h_reg != cur_m_reg) && (cur_v_reg != cur_m_reg));

    always_comb begin
        tb_ent = '0;
        unique case (mode_reg)
            MODE_V: tb_ent.sym = l1_reg;
            MODE_H: tb_ent.sym = l2_reg;
            default: begin
                tb_ent.sym  = l1_reg;
                tb_ent.pair = 1'b1;
                tb_ent.pos1 = POS_W'(i_reg - 1'b1);
                tb_ent.pos2 = POS_W'(j_reg - 1'b1);
            end
        endcase
        rb_wd = tb_ent;
        rb_we = 1'b0;
        if (cmd == CMD_TB_C) begin
            rb_we = tb_step;
        end else if (cmd == CMD_TAIL_WR) begin
            rb_we  = 1'b1;
            rb_wd  = '0;
            rb_wd.sym = (j_reg != '0) ? l2_q : l1_q;
        end
    end

    agga_ram #(.WIDTH(TR_W), .DEPTH(RBD), .AW(RAW)) u_reverse_ram (
        .aclk    (aclk),
        .wr_en   (rb_we),
        .wr_addr (RAW'(cnt_reg)),
        .wr_data (rb_wd),
        .rd_addr (RAW'(cnt_reg - k_reg - 1'b1)),
        .rd_data (rb_q)
    );

    // Control registers: configuration, lengths, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_reg      <= -7'sd11;
            ge_reg      <= -5'sd1;
            n1_reg      <= '0;
            n2_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_addr == CFG_GAP_OPEN) begin
                    go_reg <= $signed(cfg_data);
                end else begin
                    ge_reg <= $signed(cfg_data[GE_W-1:0]);
                end
            end
            if (l1_we) begin
                n1_reg <= n1_reg + 1'b1;
            end
            if (l2_we) begin
                n2_reg <= n2_reg + 1'b1;
            end
            if (cmd == CMD_FINISH) begin
                n1_reg <= '0;
                n2_reg <= '0;
            end
            if (cmd == CMD_EMIT_LD) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers: advance counters and latch operands per command
    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready) begin
            k_reg <= k_reg + 1'b1;
        end
        unique case (cmd)
            CMD_INIT_ORG: begin
                col_bnd_reg  <= score_t'(go_s + ge_s);
                row_bnd_reg  <= score_t'(go_s + ge_s);
                row_prev_reg <= '0;
                i_reg        <= IW'(1);
                j_reg        <= IW'(1);
            end
            CMD_INIT_COL: begin
                if (status.init_more) begin
                    col_bnd_reg <= score_t'(col_bnd_reg + ge_s);
                    i_reg       <= i_reg + 1'b1;
                end
            end
            CMD_COL_START: begin
                diag_reg     <= row_prev_reg;
                up_m_reg     <= row_bnd_reg;
                up_v_reg     <= NEG_INF;
                row_prev_reg <= row_bnd_reg;
                row_bnd_reg  <= score_t'(row_bnd_reg + ge_s);
                i_reg        <= IW'(1);
            end
            CMD_COL_LAT: l2_reg <= l2_q;
            CMD_CELL_SUB: begin
                left_m_reg <= m_q_s;
                left_h_reg <= h_q_s;
            end
            CMD_CELL_CALC: begin
                diag_reg <= left_m_reg;
                up_m_reg <= mx;
                up_v_reg <= vx;
                i_reg    <= i_reg + 1'b1;
            end
            CMD_COL_END: j_reg <= j_reg + 1'b1;
            CMD_TB_INIT: begin
                i_reg   <= n1_reg;
                j_reg   <= n2_reg;
                cnt_reg <= '0;
                k_reg   <= '0;
            end
            CMD_TB_SET: begin
                if (v_q_s > m_q_s) begin
                    mode_reg <= MODE_V;
                end else if (h_q_s > m_q_s) begin
                    mode_reg <= MODE_H;
                end else begin
                    mode_reg <= MODE_M;
                end
            end
            CMD_TB_B: begin
                cur_m_reg <= m_q_s;
                cur_h_reg <= h_q_s;
                cur_v_reg <= v_q_s;
                l1_reg    <= l1_q;
                l2_reg    <= l2_q;
            end
            CMD_TB_C: begin
                if (tb_step) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                unique case (mode_reg)
                    MODE_V: begin
                        if (cur_v_reg != add_cost(v_q_s, ge_s)) begin
                            mode_reg <= MODE_M;
                        end
                        i_reg <= i_reg - 1'b1;
                    end
                    MODE_H: begin
                        if (cur_h_reg != add_cost(h_q_s, ge_s)) begin
                            mode_reg <= MODE_M;
                        end
                        j_reg <= j_reg - 1'b1;
                    end
                    default: begin
                        if (cur_h_reg == cur_m_reg) begin
                            mode_reg <= MODE_H;
                        end else if (cur_v_reg == cur_m_reg) begin
                            mode_reg <= MODE_V;
                        end else begin
                            i_reg <= i_reg - 1'b1;
                            j_reg <= j_reg - 1'b1;
                        end
                    end
                endcase
            end
            CMD_TAIL_WR: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (j_reg != '0) begin
                    j_reg <= j_reg - 1'b1;
                end else begin
                    i_reg <= i_reg - 1'b1;
                end
            end
            CMD_EMIT_LD: begin
                out_reg  <= rb_ent;
                last_reg <= (CW'(k_reg + 1'b1) == cnt_reg);
            end
            default: ;
        endcase
    end

    // Status back to the controller
    assign status.init_more = (i_reg <= n1_reg);
    assign status.col_last  = (j_reg == n2_reg);
    assign status.n2_zero   = (n2_reg == '0);
    assign status.cell_last = (i_reg == n1_reg);
    assign status.tb_loop   = (i_reg != '0) && (j_reg != '0);
    assign status.tail_any  = (i_reg != '0) || (j_reg != '0);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.out_last  = last_reg;
    assign status.out_taken = m_valid_reg && m_ready;

    assign m_valid           = m_valid_reg;
    assign m_merged_symbol   = out_reg.sym;
    assign m_is_pair         = out_reg.pair;
    assign m_first_position  = out_reg.pos1;
    assign m_second_position = out_reg.pos2;
    assign m_last            = last_reg;

endmodule

// ----- rtl/affine_gap_global_aligner_core.sv -----
// Load items (letters, table entries) are accepted back to back while idle.
// An align item fills the score memories one cell at a time (read,
// substitution and calculate states on the shared score RAM ports), walks
// the traceback one step at a time, then emits each merged position and waits for each to be taken.
// Synchronous active-low reset clears both lengths and sets gap_open to -11,
// gap_extend to -1; memories are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`include "affine_gap_global_aligner_core_defines.svh"
module affine_gap_global_aligner_core #(
    parameter int MAX_LEN = agga_pkg::MAX_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [agga_pkg::OP_W-1:0]          s_op,
    input  logic [agga_pkg::SYM_W-1:0]         s_symbol,
    input  logic [agga_pkg::SYM_W-1:0]         s_column_symbol,
    input  logic signed [agga_pkg::ENTRY_W-1:0] s_entry_score,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [agga_pkg::SYM_W-1:0]         m_merged_symbol,
    output logic                               m_is_pair,
    output logic [agga_pkg::POS_W-1:0]         m_first_position,
    output logic [agga_pkg::POS_W-1:0]         m_second_position,
    output logic                               m_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [agga_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [agga_pkg::GO_W-1:0]          cfg_data
);
    import agga_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;

    agga_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    agga_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_op              (s_op),
        .s_symbol          (s_symbol),
        .s_column_symbol   (s_column_symbol),
        .s_entry_score     (s_entry_score),
        .cfg_valid         (cfg_valid),
        .cfg_addr          (cfg_addr),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_merged_symbol   (m_merged_symbol),
        .m_is_pair         (m_is_pair),
        .m_first_position  (m_first_position),
        .m_second_position (m_second_position),
        .m_last            (m_last)
    );

    // A result is never offered while a new input item could be taken
    `AGGA_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "result while input open")
    // Accepting an align item starts the busy phase
    `AGGA_ASSERT_NEXT(a_align_busy, aclk, aresetn, s_valid && s_ready && (s_op == OP_ALIGN), !s_ready, "align not started")
    // The final result transfer ends the output burst
    `AGGA_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_last, !m_valid, "result after last")

endmodule
